// File: hw/rtl/tpqm_pkg.sv
`default_nettype none

package tpqm_pkg;

  localparam int unsigned IDX_W      = 5;
  localparam int unsigned LINK_DEPTH = 32;
  localparam int unsigned OP_W       = 3;

  localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(LINK_DEPTH - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_FREE      = 3'd1,
    OP_INS_FRONT = 3'd2,
    OP_INS_BACK  = 3'd3,
    OP_RM_HEAD   = 3'd4,
    OP_RM_ENTRY  = 3'd5,
    OP_HEAD      = 3'd6
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic             tail_valid;
    logic [IDX_W-1:0] tail_index;
    logic [IDX_W-1:0] entry_index;
  } tpqm_req_t;

  typedef struct packed {
    logic             found_valid;
    logic [IDX_W-1:0] found_index;
    logic             new_tail_valid;
    logic [IDX_W-1:0] new_tail_index;
  } tpqm_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/tpqm_link_ram.sv
`default_nettype none

module tpqm_link_ram
  import tpqm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [IDX_W-1:0] wdata_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [IDX_W-1:0] rdata_o
);

  logic [IDX_W-1:0] mem [LINK_DEPTH];
  logic [IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/thread_pool_queue_manager.sv
`default_nettype none

// Pool allocator and circular doubly linked queue manager. One transaction is
// taken while busy is low and start is high; its result appears on rsp_o with
// done_o, high for exactly one cycle, and the receiver cannot stall it. Alloc,
// free, the unused opcode and any queue operation on an empty queue answer in
// the cycle after acceptance and a new transaction may follow at once. Head goes
// through S_HEAD_R, remove head through S_RMH_H and, but for a lone entry,
// S_RMH_N, insert front or back through S_INS_W1 and S_INS_W2. Remove entry
// walks the next-link memory one entry per cycle from the tail; a hit goes on
// through S_RME_R and, if other entries remain, S_RME_W; a miss ends at the tail
// or at step STEP_LAST. The item after a done cycle may be accepted in that
// same cycle. Link memories need no initialization pass.
module thread_pool_queue_manager
  import tpqm_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire tpqm_req_t req_i,
  output logic           done_o,
  output tpqm_rsp_t      rsp_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_INS_W1 = 9'b000000010,
    S_INS_W2 = 9'b000000100,
    S_RMH_H  = 9'b000001000,
    S_RMH_N  = 9'b000010000,
    S_HEAD_R = 9'b000100000,
    S_WALK   = 9'b001000000,
    S_RME_R  = 9'b010000000,
    S_RME_W  = 9'b100000000
  } state_e;

  state_e                 state_q, state_d;
  tpqm_req_t              req_q, req_d;
  logic [IDX_W-1:0]       aux_q, aux_d;
  logic [IDX_W-1:0]       step_q, step_d;
  logic                   first_q, first_d;
  logic [NUM_ENTRIES-1:0] used_q, used_d;
  tpqm_rsp_t              rsp_q, rsp_d;
  logic                   done_q, done_d;

  logic                   next_we, prev_we;
  logic [IDX_W-1:0]       next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic [IDX_W-1:0]       next_raddr, prev_raddr;
  logic [IDX_W-1:0]       next_rdata, prev_rdata;

  logic [NUM_ENTRIES-1:0] free_vec, low_vec, clr_vec;
  logic [IDX_W-1:0]       alloc_idx;
  logic                   any_free;
  logic [IDX_W-1:0]       cur;
  logic                   accept;

  function automatic tpqm_rsp_t pack_rsp(input logic fv, input logic [IDX_W-1:0] fi,
                                         input logic tv, input logic [IDX_W-1:0] ti);
    tpqm_rsp_t r;
    r.found_valid    = fv;
    r.found_index    = fv ? fi : '0;
    r.new_tail_valid = tv;
    r.new_tail_index = tv ? ti : '0;
    return r;
  endfunction

  tpqm_link_ram u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  tpqm_link_ram u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    free_vec  = ~used_q;
    low_vec   = free_vec & (~free_vec + NUM_ENTRIES'(1));
    any_free  = |free_vec;
    alloc_idx = '0;
    clr_vec   = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (low_vec[i]) begin
        alloc_idx = alloc_idx | IDX_W'(i);
      end
      if (req_i.entry_index == IDX_W'(i)) begin
        clr_vec[i] = 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    aux_d      = aux_q;
    step_d     = step_q;
    first_d    = first_q;
    used_d     = used_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    next_waddr = req_q.entry_index;
    next_wdata = req_q.entry_index;
    prev_waddr = req_q.entry_index;
    prev_wdata = req_q.entry_index;
    next_raddr = req_q.tail_index;
    prev_raddr = req_q.entry_index;
    cur        = first_q ? req_q.tail_index : next_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d      = req_i;
          next_raddr = req_i.tail_index;
          rsp_d      = pack_rsp(1'b0, '0, req_i.tail_valid, req_i.tail_index);
          unique case (op_e'(req_i.opcode)) inside
            OP_ALLOC: begin
              done_d = 1'b1;
              if (any_free) begin
                used_d = used_q | low_vec;
                rsp_d  = pack_rsp(1'b1, alloc_idx, req_i.tail_valid, req_i.tail_index);
              end
            end
            OP_FREE: begin
              done_d = 1'b1;
              used_d = used_q & ~clr_vec;
            end
            OP_INS_FRONT, OP_INS_BACK: begin
              if (req_i.tail_valid) begin
                state_d = S_INS_W1;
              end else begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                next_waddr = req_i.entry_index;
                next_wdata = req_i.entry_index;
                prev_waddr = req_i.entry_index;
                prev_wdata = req_i.entry_index;
                rsp_d      = pack_rsp(1'b0, '0, 1'b1, req_i.entry_index);
                done_d     = 1'b1;
              end
            end
            OP_RM_HEAD: begin
              if (req_i.tail_valid) begin
                state_d = S_RMH_H;
              end else begin
                done_d = 1'b1;
              end
            end
            OP_HEAD: begin
              if (req_i.tail_valid) begin
                state_d = S_HEAD_R;
              end else begin
                done_d = 1'b1;
              end
            end
            OP_RM_ENTRY: begin
              if (req_i.tail_valid) begin
                state_d = S_WALK;
                first_d = 1'b1;
                step_d  = '0;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_INS_W1: begin
        aux_d      = next_rdata;
        next_we    = 1'b1;
        next_waddr = req_q.entry_index;
        next_wdata = next_rdata;
        prev_we    = 1'b1;
        prev_waddr = req_q.entry_index;
        prev_wdata = req_q.tail_index;
        state_d    = S_INS_W2;
      end
      S_INS_W2: begin
        next_we    = 1'b1;
        next_waddr = req_q.tail_index;
        next_wdata = req_q.entry_index;
        prev_we    = 1'b1;
        prev_waddr = (req_q.entry_index == req_q.tail_index) ? req_q.entry_index : aux_q;
        prev_wdata = req_q.entry_index;
        rsp_d      = pack_rsp(1'b0, '0, 1'b1,
                              (op_e'(req_q.opcode) == OP_INS_BACK) ? req_q.entry_index
                                                                   : req_q.tail_index);
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      S_RMH_H: begin
        if (next_rdata == req_q.tail_index) begin
          rsp_d   = pack_rsp(1'b1, next_rdata, 1'b0, '0);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          aux_d      = next_rdata;
          next_raddr = next_rdata;
          state_d    = S_RMH_N;
        end
      end
      S_RMH_N: begin
        prev_we    = 1'b1;
        prev_waddr = next_rdata;
        prev_wdata = req_q.tail_index;
        next_we    = 1'b1;
        next_waddr = req_q.tail_index;
        next_wdata = next_rdata;
        rsp_d      = pack_rsp(1'b1, aux_q, 1'b1, req_q.tail_index);
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      S_HEAD_R: begin
        rsp_d   = pack_rsp(1'b1, next_rdata, 1'b1, req_q.tail_index);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_WALK: begin
        if (!first_q && (cur == req_q.tail_index)) begin
          rsp_d   = pack_rsp(1'b0, '0, 1'b1, req_q.tail_index);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (cur == req_q.entry_index) begin
          next_raddr = req_q.tail_index;
          prev_raddr = req_q.entry_index;
          state_d    = S_RME_R;
        end else if (step_q == STEP_LAST) begin
          rsp_d   = pack_rsp(1'b0, '0, 1'b1, req_q.tail_index);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          next_raddr = cur;
          step_d     = step_q + IDX_W'(1);
          first_d    = 1'b0;
        end
      end
      S_RME_R: begin
        if (next_rdata == req_q.tail_index) begin
          rsp_d   = pack_rsp(1'b1, req_q.entry_index, 1'b0, '0);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          aux_d      = prev_rdata;
          next_raddr = req_q.entry_index;
          state_d    = S_RME_W;
        end
      end
      S_RME_W: begin
        next_we    = 1'b1;
        next_waddr = aux_q;
        next_wdata = next_rdata;
        prev_we    = 1'b1;
        prev_waddr = next_rdata;
        prev_wdata = aux_q;
        rsp_d      = pack_rsp(1'b1, req_q.entry_index, 1'b1,
                              (req_q.tail_index == req_q.entry_index) ? aux_q
                                                                      : req_q.tail_index);
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      done_q  <= done_d;
      first_q <= first_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    aux_q <= aux_d;
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // every accepted transaction either answers next cycle or holds the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_o || busy))
    else $error("accepted transaction neither answered nor in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("sequencer returned to idle without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_e'(req_i.opcode) == OP_ALLOC)) |=> done_o && !busy)
    else $error("alloc did not answer in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.found_valid && $past(accept)
     && ($past(req_i.opcode) == OP_ALLOC))
    |-> ((($past(used_q) >> rsp_o.found_index) & NUM_ENTRIES'(1)) == '0))
    else $error("alloc returned an entry already in use");

endmodule

`default_nettype wire
